// ===== design/ibm_pkg.sv =====
// ----------------------------------------------------------------------------
// ibm_pkg
// shared constants, codes and types for the inode bitmap allocator
// ----------------------------------------------------------------------------
package ibm_pkg;

  localparam int MAX_ENTRIES = 8192;
  localparam int WORD_W      = 64;
  localparam int NUM_WORDS   = MAX_ENTRIES / WORD_W;
  localparam int ADDR_W      = $clog2(NUM_WORDS);
  localparam int BIT_W       = $clog2(WORD_W);
  localparam int LOCAL_W     = 13;
  localparam int SIZE_W      = 14;
  localparam int GROUP_W     = 16;
  localparam int GIDX_W      = 29;
  localparam int PROD_W      = SIZE_W + GROUP_W;
  localparam int IN_DATA_W   = 16;
  localparam int OUT_DATA_W  = 48;
  localparam int CFG_ADDR_W  = 3;
  localparam int CFG_DATA_W  = 32;

  localparam logic [SIZE_W-1:0] MAX_SIZE = SIZE_W'(MAX_ENTRIES);

  typedef enum logic [1:0] {
    MODE_ALLOC = 2'd0,
    MODE_CLAIM = 2'd1,
    MODE_QUERY = 2'd2,
    MODE_NOP   = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_FAIL  = 2'd1,
    STAT_RANGE = 2'd2
  } status_t;

  localparam logic REG_SIZE  = 1'b0;
  localparam logic REG_GROUP = 1'b1;

  typedef logic [ADDR_W-1:0] word_addr_t;
  typedef logic [WORD_W-1:0] map_word_t;

endpackage

// ===== design/ibm_map_ram.sv =====
// ----------------------------------------------------------------------------
// ibm_map_ram
// used-bit map storage, one 64-bit word per row, registered read, per-row
// valid flags so that rows never written read back as all free
// ----------------------------------------------------------------------------
module ibm_map_ram
  import ibm_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       rd_en,
  input  word_addr_t rd_addr,
  output map_word_t  rd_data,
  input  logic       wr_en,
  input  word_addr_t wr_addr,
  input  map_word_t  wr_data
);

  map_word_t              mem [NUM_WORDS];
  logic [NUM_WORDS-1:0]   row_valid_r;
  map_word_t              rd_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_valid_r <= '0;
    end else if (wr_en) begin
      row_valid_r[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= row_valid_r[rd_addr] ? mem[rd_addr] : '0;
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== design/ibm_zero_find.sv =====
// ----------------------------------------------------------------------------
// ibm_zero_find
// lowest clear bit of one map word, isolated by a two's complement trick
// ----------------------------------------------------------------------------
module ibm_zero_find
  import ibm_pkg::*;
(
  input  map_word_t        word,
  output logic             found,
  output logic [BIT_W-1:0] pos
);

  map_word_t        inv;
  map_word_t        iso;
  logic [BIT_W-1:0] pos_v;

  assign inv   = ~word;
  assign iso   = inv & (~inv + map_word_t'(1));
  assign found = |inv;

  always_comb begin
    pos_v = '0;
    for (int i = 0; i < WORD_W; i++) begin
      if (iso[i]) begin
        pos_v = pos_v | BIT_W'(i);
      end
    end
  end

  assign pos = pos_v;

endmodule

// ===== design/inode_bitmap_allocator_unit.sv =====
// ----------------------------------------------------------------------------
// inode_bitmap_allocator_unit
// first-free allocator over one block group's inode used-bit map
// ----------------------------------------------------------------------------
// One request is handled at a time and in_tready is low while it is in work.
// Allocate reads the map one 64-bit word per cycle from word 0 and runs a
// single lowest-clear-bit unit on each word, scanning up to 128 words at
// 8192 entries; claim and query read and check the addressed word, while
// the unused mode, a number out of range and an allocate with no free entry
// go straight to the done state.
// The map needs no clearing pass after reset: each row has a valid flag and
// unwritten rows read as free. A finished result waits in the output
// register, and the next request is taken while it waits; that request then
// holds in its last cycle until the output register has been emptied.
// ----------------------------------------------------------------------------
module inode_bitmap_allocator_unit
  import ibm_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // inode_number
  input  logic [1:0]            in_tuser,   // mode
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // global_index, entry_free, free_count, any_free
  output logic [1:0]            out_tuser,  // status
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic [CFG_DATA_W-1:0] cfg_prdata,
  output logic                  cfg_pready
);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_CHECK = 4'b0010,
    S_SCAN  = 4'b0100,
    S_DONE  = 4'b1000
  } state_t;

  state_t              state_r, state_nxt;
  mode_t               mode_r, mode_nxt;
  logic [LOCAL_W-1:0]  num_r, num_nxt;
  word_addr_t          ptr_r, ptr_nxt;
  status_t             status_r, status_nxt;
  logic [LOCAL_W-1:0]  local_r, local_nxt;
  logic                hit_r, hit_nxt;
  logic                efree_r, efree_nxt;
  logic [SIZE_W-1:0]   used_r, used_nxt;
  logic [SIZE_W-1:0]   ipg_r, ipg_nxt;
  logic [GROUP_W-1:0]  grp_r, grp_nxt;
  logic [PROD_W-1:0]   prod_r;

  logic                out_valid_r, out_valid_nxt;
  status_t             o_status_r, o_status_nxt;
  logic [GIDX_W-1:0]   o_gidx_r, o_gidx_nxt;
  logic                o_efree_r, o_efree_nxt;
  logic [SIZE_W-1:0]   o_fc_r, o_fc_nxt;
  logic                o_any_r, o_any_nxt;

  logic                cfg_wr;
  logic [SIZE_W-1:0]   size_n;
  logic [SIZE_W-1:0]   free_now;
  word_addr_t          last_word;
  logic [ADDR_W:0]     full_words;
  map_word_t           low_mask;
  map_word_t           scan_word;
  logic                zf_found;
  logic [BIT_W-1:0]    zf_pos;
  mode_t               in_mode;
  logic [LOCAL_W-1:0]  in_num;

  logic                rd_en;
  word_addr_t          rd_addr;
  map_word_t           rd_data;
  logic                wr_en;
  word_addr_t          wr_addr;
  map_word_t           wr_data;

  // configuration port
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;

  always_comb begin
    ipg_nxt = ipg_r;
    grp_nxt = grp_r;
    if (cfg_wr) begin
      case (cfg_paddr[2])
        REG_SIZE:  ipg_nxt = cfg_pwdata[SIZE_W-1:0];
        REG_GROUP: grp_nxt = cfg_pwdata[GROUP_W-1:0];
        default:   ;
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr[2])
      REG_SIZE:  cfg_prdata = CFG_DATA_W'(ipg_r);
      REG_GROUP: cfg_prdata = CFG_DATA_W'(grp_r);
      default:   cfg_prdata = '0;
    endcase
  end

  // size, free count and scan limits
  assign size_n     = (ipg_r > MAX_SIZE) ? MAX_SIZE : ipg_r;
  assign free_now   = (size_n > used_r) ? (size_n - used_r) : '0;
  assign last_word  = ADDR_W'((size_n - SIZE_W'(1)) >> BIT_W);
  assign full_words = (ADDR_W+1)'(size_n >> BIT_W);

  always_comb begin
    for (int b = 0; b < WORD_W; b++) begin
      low_mask[b] = (BIT_W'(b) < size_n[BIT_W-1:0]);
    end
  end

  assign scan_word = ({1'b0, ptr_r} < full_words) ? rd_data : (rd_data | ~low_mask);

  ibm_zero_find u_find (
    .word  (scan_word),
    .found (zf_found),
    .pos   (zf_pos)
  );

  ibm_map_ram u_map (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  assign in_mode   = mode_t'(in_tuser);
  assign in_num    = in_tdata[LOCAL_W-1:0];
  assign in_tready = (state_r == S_IDLE);

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    mode_nxt      = mode_r;
    num_nxt       = num_r;
    ptr_nxt       = ptr_r;
    status_nxt    = status_r;
    local_nxt     = local_r;
    hit_nxt       = hit_r;
    efree_nxt     = efree_r;
    used_nxt      = used_r;
    rd_en         = 1'b0;
    rd_addr       = ptr_r + word_addr_t'(1);
    wr_en         = 1'b0;
    wr_addr       = ptr_r;
    wr_data       = rd_data;
    out_valid_nxt = out_valid_r & ~out_tready;
    o_status_nxt  = o_status_r;
    o_gidx_nxt    = o_gidx_r;
    o_efree_nxt   = o_efree_r;
    o_fc_nxt      = o_fc_r;
    o_any_nxt     = o_any_r;

    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          mode_nxt   = in_mode;
          num_nxt    = in_num;
          ptr_nxt    = '0;
          status_nxt = STAT_OK;
          hit_nxt    = 1'b0;
          efree_nxt  = 1'b0;
          local_nxt  = in_num;
          case (in_mode)
            MODE_ALLOC: begin
              if (free_now == '0) begin
                status_nxt = STAT_FAIL;
                state_nxt  = S_DONE;
              end else begin
                rd_en     = 1'b1;
                rd_addr   = '0;
                state_nxt = S_SCAN;
              end
            end
            MODE_CLAIM, MODE_QUERY: begin
              if ({1'b0, in_num} >= size_n) begin
                status_nxt = STAT_RANGE;
                state_nxt  = S_DONE;
              end else begin
                rd_en     = 1'b1;
                rd_addr   = in_num[LOCAL_W-1:BIT_W];
                state_nxt = S_CHECK;
              end
            end
            default: state_nxt = S_DONE;
          endcase
        end
      end

      S_CHECK: begin
        state_nxt = S_DONE;
        if (mode_r == MODE_QUERY) begin
          efree_nxt = ~rd_data[num_r[BIT_W-1:0]];
        end else if (rd_data[num_r[BIT_W-1:0]]) begin
          status_nxt = STAT_FAIL;
        end else begin
          wr_en     = 1'b1;
          wr_addr   = num_r[LOCAL_W-1:BIT_W];
          wr_data   = rd_data | (map_word_t'(1) << num_r[BIT_W-1:0]);
          used_nxt  = used_r + SIZE_W'(1);
          hit_nxt   = 1'b1;
        end
      end

      S_SCAN: begin
        if (zf_found) begin
          wr_en     = 1'b1;
          wr_addr   = ptr_r;
          wr_data   = rd_data | (map_word_t'(1) << zf_pos);
          used_nxt  = used_r + SIZE_W'(1);
          hit_nxt   = 1'b1;
          local_nxt = {ptr_r, zf_pos};
          state_nxt = S_DONE;
        end else if (ptr_r == last_word) begin
          status_nxt = STAT_FAIL;
          state_nxt  = S_DONE;
        end else begin
          rd_en   = 1'b1;
          ptr_nxt = ptr_r + word_addr_t'(1);
        end
      end

      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          o_status_nxt  = status_r;
          o_gidx_nxt    = hit_r ? (prod_r[GIDX_W-1:0] + GIDX_W'(local_r)) : '0;
          o_efree_nxt   = efree_r;
          o_fc_nxt      = free_now;
          o_any_nxt     = (free_now != '0);
          state_nxt     = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      used_r      <= '0;
      ipg_r       <= MAX_SIZE;
      grp_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      used_r      <= used_nxt;
      ipg_r       <= ipg_nxt;
      grp_r       <= grp_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mode_r     <= mode_nxt;
    num_r      <= num_nxt;
    ptr_r      <= ptr_nxt;
    status_r   <= status_nxt;
    local_r    <= local_nxt;
    hit_r      <= hit_nxt;
    efree_r    <= efree_nxt;
    prod_r     <= grp_r * ipg_r;
    o_status_r <= o_status_nxt;
    o_gidx_r   <= o_gidx_nxt;
    o_efree_r  <= o_efree_nxt;
    o_fc_r     <= o_fc_nxt;
    o_any_r    <= o_any_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = o_status_r;
  assign out_tdata  = {3'b000, o_any_r, o_fc_r, o_efree_r, o_gidx_r};

endmodule

// ===== design/ibm_checker.sv =====
// ----------------------------------------------------------------------------
// ibm_checker
// port-level checks for the inode bitmap allocator, bound to the top level
// ----------------------------------------------------------------------------
module ibm_checker
  import ibm_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_tvalid,
  input logic                  in_tready,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [OUT_DATA_W-1:0] out_tdata,
  input logic [1:0]            out_tuser
);

  // one request in work at a time
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input taken again straight after a transaction");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result changed");

  a_any_free: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[44] == (out_tdata[43:30] != 14'd0)))
    else $error("any_free disagrees with free_count");

  a_no_index_on_fail: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser != STAT_OK) |-> (out_tdata[28:0] == 29'd0) && !out_tdata[29])
    else $error("index or entry flag given with a failing status");

endmodule

bind inode_bitmap_allocator_unit ibm_checker u_ibm_checker (.*);
